[sv/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in every cycle outside reset.
`define CHK_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/i2cms_pkg.sv]
// Types and constants of the I2C master bit sequencer.
package i2cms_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned STEP_W = 5;

  localparam logic [TICK_W-1:0] STEP_TICKS_RESET = 16'd8;

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_SEND_ACK = 3'd4,
    CMD_READ_ACK = 3'd5
  } cmd_t;

  // Position within a three-step bit slot of the byte commands.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [2:0]        command;
    logic [DATA_W-1:0] write_data;
    logic              ack_out;
    logic              sda_sample;
  } req_item_t;

  function automatic logic [STEP_W-1:0] step_total(input cmd_t cmd);
    logic [STEP_W-1:0] total;
    case (cmd)
      CMD_START:    total = 5'd4;
      CMD_STOP:     total = 5'd3;
      CMD_WRITE:    total = 5'd24;
      CMD_READ:     total = 5'd25;
      CMD_SEND_ACK: total = 5'd3;
      CMD_READ_ACK: total = 5'd4;
      default:      total = 5'd4;
    endcase
    return total;
  endfunction

endpackage

[sv/i2cms_if.sv]
// Handshake interfaces for the request and response channels.
interface i2cms_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [2:0]                    command;
  logic [i2cms_pkg::DATA_W-1:0]  write_data;
  logic                          ack_out;
  logic                          sda_sample;

  modport source (output valid, kind, command, write_data, ack_out, sda_sample,
                  input ready);
  modport sink   (input valid, kind, command, write_data, ack_out, sda_sample,
                  output ready);
endinterface

interface i2cms_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          scl_level;
  logic                          sda_level;
  logic                          busy_res;
  logic                          done_res;
  logic [i2cms_pkg::DATA_W-1:0]  read_data;
  logic                          ack_in;
  logic                          rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                  ack_in, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                  ack_in, rejected, output ready);
endinterface

[sv/i2c_master_bit_sequencer.sv]
// I2C master bit sequencer top level.
// Each transfer on req is either a command or a tick. A known command taken while idle
// starts a bus operation and applies its first pin step at once; a command taken while
// busy is rejected and an unknown one is ignored. A tick advances the running operation
// by one tick and moves on to the next pin step after step_ticks ticks, a zero counting
// as one. Every request transfer yields exactly one response transfer with the pin
// drives, busy, done, reject and read results. The block takes one transfer per clock
// cycle. A request is held in the input register and its response in the output
// register, from which rsp offers it. Back-pressure on rsp stalls req once both registers are full.
module i2c_master_bit_sequencer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step_ticks_we,
  input  logic [i2cms_pkg::TICK_W-1:0]          step_ticks_wdata,
  i2cms_req_if.sink                             req,
  i2cms_rsp_if.source                           rsp
);

  i2cms_pkg::req_item_t                 item;
  logic                                 item_valid;
  logic                                 fire;

  logic [i2cms_pkg::TICK_W-1:0]         step_ticks;
  i2cms_pkg::cmd_t                      active_command;
  logic [i2cms_pkg::STEP_W-1:0]         step_index;
  i2cms_pkg::phase_t                    phase;
  logic [i2cms_pkg::TICK_W-1:0]         tick_count;
  logic [i2cms_pkg::DATA_W-1:0]         shift_byte;
  logic [i2cms_pkg::DATA_W-1:0]         received_byte;
  logic                                 received_ack;
  logic                                 scl_drive;
  logic                                 sda_drive;
  logic                                 busy_flag;
  logic                                 out_valid;

  i2cms_pkg::cmd_t                      active_command_next;
  logic [i2cms_pkg::STEP_W-1:0]         step_index_next;
  i2cms_pkg::phase_t                    phase_next;
  logic [i2cms_pkg::TICK_W-1:0]         tick_count_next;
  logic [i2cms_pkg::DATA_W-1:0]         shift_byte_next;
  logic [i2cms_pkg::DATA_W-1:0]         received_byte_next;
  logic                                 received_ack_next;
  logic                                 scl_drive_next;
  logic                                 sda_drive_next;
  logic                                 busy_flag_next;
  logic                                 done_next;
  logic                                 rejected_next;

  logic [i2cms_pkg::TICK_W-1:0]         limit;
  logic [i2cms_pkg::TICK_W-1:0]         tick_inc;
  logic [i2cms_pkg::STEP_W-1:0]         step_inc;
  logic                                 cmd_known;
  logic                                 apply;
  i2cms_pkg::cmd_t                      item_cmd;

  assign fire      = item_valid && (!out_valid || rsp.ready);
  assign req.ready = !item_valid || fire;

  assign limit    = (step_ticks == '0) ? 16'd1 : step_ticks;
  assign tick_inc = tick_count + 16'd1;
  assign step_inc = step_index + 5'd1;
  assign item_cmd = i2cms_pkg::cmd_t'(item.command);

  always_comb begin
    case (item_cmd)
      i2cms_pkg::CMD_START, i2cms_pkg::CMD_STOP, i2cms_pkg::CMD_WRITE,
      i2cms_pkg::CMD_READ, i2cms_pkg::CMD_SEND_ACK, i2cms_pkg::CMD_READ_ACK: begin
        cmd_known = 1'b1;
      end
      default: begin
        cmd_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    active_command_next = active_command;
    step_index_next     = step_index;
    phase_next          = phase;
    tick_count_next     = tick_count;
    shift_byte_next     = shift_byte;
    received_byte_next  = received_byte;
    received_ack_next   = received_ack;
    scl_drive_next      = scl_drive;
    sda_drive_next      = sda_drive;
    busy_flag_next      = busy_flag;
    done_next           = 1'b0;
    rejected_next       = 1'b0;
    apply               = 1'b0;

    if (item.kind == i2cms_pkg::KIND_COMMAND) begin
      if (busy_flag) begin
        rejected_next = 1'b1;
      end else if (cmd_known) begin
        active_command_next = item_cmd;
        step_index_next     = '0;
        phase_next          = i2cms_pkg::PH_FIRST;
        tick_count_next     = '0;
        busy_flag_next      = 1'b1;
        apply               = 1'b1;
        case (item_cmd)
          i2cms_pkg::CMD_WRITE:    shift_byte_next = item.write_data;
          i2cms_pkg::CMD_READ:     shift_byte_next = '0;
          i2cms_pkg::CMD_SEND_ACK: sda_drive_next  = item.ack_out;
          default: ;
        endcase
      end
    end else if (busy_flag) begin
      tick_count_next = tick_inc;
      if (tick_inc >= limit) begin
        tick_count_next = '0;
        if (step_inc >= i2cms_pkg::step_total(active_command)) begin
          busy_flag_next  = 1'b0;
          done_next       = 1'b1;
          step_index_next = '0;
          if (active_command == i2cms_pkg::CMD_READ) begin
            received_byte_next = shift_byte;
          end
        end else begin
          step_index_next = step_inc;
          apply           = 1'b1;
          if (active_command == i2cms_pkg::CMD_READ && step_index == '0) begin
            phase_next = i2cms_pkg::PH_FIRST;
          end else begin
            case (phase)
              i2cms_pkg::PH_FIRST:  phase_next = i2cms_pkg::PH_SECOND;
              i2cms_pkg::PH_SECOND: phase_next = i2cms_pkg::PH_THIRD;
              default:              phase_next = i2cms_pkg::PH_FIRST;
            endcase
          end
        end
      end
    end

    if (apply) begin
      case (active_command_next)
        i2cms_pkg::CMD_START: begin
          case (step_index_next)
            5'd0:    sda_drive_next = 1'b1;
            5'd1:    scl_drive_next = 1'b1;
            5'd2:    sda_drive_next = 1'b0;
            default: scl_drive_next = 1'b0;
          endcase
        end
        i2cms_pkg::CMD_STOP: begin
          case (step_index_next)
            5'd0:    sda_drive_next = 1'b0;
            5'd1:    scl_drive_next = 1'b1;
            default: sda_drive_next = 1'b1;
          endcase
        end
        i2cms_pkg::CMD_WRITE: begin
          case (phase_next)
            i2cms_pkg::PH_FIRST:  sda_drive_next = shift_byte_next[i2cms_pkg::DATA_W-1];
            i2cms_pkg::PH_SECOND: scl_drive_next = 1'b1;
            default: begin
              scl_drive_next  = 1'b0;
              shift_byte_next = {shift_byte_next[i2cms_pkg::DATA_W-2:0], 1'b0};
            end
          endcase
        end
        i2cms_pkg::CMD_READ: begin
          if (step_index_next == '0) begin
            sda_drive_next = 1'b1;
          end else begin
            case (phase_next)
              i2cms_pkg::PH_FIRST: scl_drive_next = 1'b1;
              i2cms_pkg::PH_SECOND: begin
                shift_byte_next = {shift_byte_next[i2cms_pkg::DATA_W-2:0], item.sda_sample};
              end
              default: scl_drive_next = 1'b0;
            endcase
          end
        end
        i2cms_pkg::CMD_SEND_ACK: begin
          case (step_index_next)
            5'd1:    scl_drive_next = 1'b1;
            5'd2:    scl_drive_next = 1'b0;
            default: ;
          endcase
        end
        default: begin
          case (step_index_next)
            5'd0:    sda_drive_next    = 1'b1;
            5'd1:    scl_drive_next    = 1'b1;
            5'd2:    received_ack_next = item.sda_sample;
            default: scl_drive_next    = 1'b0;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.kind       <= req.kind;
      item.command    <= req.command;
      item.write_data <= req.write_data;
      item.ack_out    <= req.ack_out;
      item.sda_sample <= req.sda_sample;
    end
    if (fire) begin
      rsp.scl_level <= scl_drive_next;
      rsp.sda_level <= sda_drive_next;
      rsp.busy_res  <= busy_flag_next;
      rsp.done_res  <= done_next;
      rsp.read_data <= received_byte_next;
      rsp.ack_in    <= received_ack_next;
      rsp.rejected  <= rejected_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid     <= 1'b0;
      out_valid      <= 1'b0;
      step_ticks     <= i2cms_pkg::STEP_TICKS_RESET;
      active_command <= i2cms_pkg::CMD_START;
      step_index     <= '0;
      phase          <= i2cms_pkg::PH_FIRST;
      tick_count     <= '0;
      shift_byte     <= '0;
      received_byte  <= '0;
      received_ack   <= 1'b1;
      scl_drive      <= 1'b1;
      sda_drive      <= 1'b1;
      busy_flag      <= 1'b0;
    end else begin
      if (req.ready) begin
        item_valid <= req.valid;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (step_ticks_we) begin
        step_ticks <= step_ticks_wdata;
      end
      if (fire) begin
        active_command <= active_command_next;
        step_index     <= step_index_next;
        phase          <= phase_next;
        tick_count     <= tick_count_next;
        shift_byte     <= shift_byte_next;
        received_byte  <= received_byte_next;
        received_ack   <= received_ack_next;
        scl_drive      <= scl_drive_next;
        sda_drive      <= sda_drive_next;
        busy_flag      <= busy_flag_next;
      end
    end
  end

  assign rsp.valid = out_valid;

endmodule

[sv/i2cms_checker.sv]
// Port-level checks of the I2C master bit sequencer and their binding.
`include "assert_macros.svh"

module i2cms_checker (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic scl_level,
  input logic sda_level,
  input logic busy_res,
  input logic done_res,
  input logic rejected
);

  `CHK_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(scl_level) && $stable(sda_level) && $stable(busy_res))
  `CHK_IMPLY(a_done_idle, clk, rst, rsp_valid && done_res, !busy_res)
  `CHK_IMPLY(a_reject_busy, clk, rst, rsp_valid && rejected, busy_res)
  `CHK_ALWAYS(a_done_or_reject, clk, rst, !(rsp_valid && done_res && rejected))

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .scl_level (rsp.scl_level),
  .sda_level (rsp.sda_level),
  .busy_res  (rsp.busy_res),
  .done_res  (rsp.done_res),
  .rejected  (rsp.rejected)
);

[sim/i2c_master_bit_sequencer_tb.sv]
// Self-checking testbench for the I2C master bit sequencer, with its own line-level predictor.
module i2c_master_bit_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct packed {
    logic                         scl_level;
    logic                         sda_level;
    logic                         busy_res;
    logic                         done_res;
    logic [i2cms_pkg::DATA_W-1:0] read_data;
    logic                         ack_in;
    logic                         rejected;
  } pin_result_t;

  class pin_scoreboard;
    logic [i2cms_pkg::TICK_W-1:0] step_ticks;
    i2cms_pkg::cmd_t              active_cmd;
    logic [i2cms_pkg::STEP_W-1:0] step_idx;
    logic [i2cms_pkg::TICK_W-1:0] tick_cnt;
    logic [i2cms_pkg::DATA_W-1:0] shift_reg;
    logic [i2cms_pkg::DATA_W-1:0] rx_byte;
    logic                         rx_ack;
    logic                         scl;
    logic                         sda;
    logic                         busy;
    pin_result_t                  pending_pins[$];
    int unsigned                  errors;

    function new();
      step_ticks = i2cms_pkg::STEP_TICKS_RESET;
      active_cmd = i2cms_pkg::CMD_START;
      step_idx   = '0;
      tick_cnt   = '0;
      shift_reg  = '0;
      rx_byte    = '0;
      rx_ack     = 1'b1;
      scl        = 1'b1;
      sda        = 1'b1;
      busy       = 1'b0;
      errors     = 0;
    endfunction

    function int unsigned op_steps(i2cms_pkg::cmd_t c);
      case (c)
        i2cms_pkg::CMD_START:    return 4;
        i2cms_pkg::CMD_STOP:     return 3;
        i2cms_pkg::CMD_WRITE:    return 24;
        i2cms_pkg::CMD_READ:     return 25;
        i2cms_pkg::CMD_SEND_ACK: return 3;
        default:                 return 4;
      endcase
    endfunction

    function void apply_step(logic sda_in);
      case (active_cmd)
        i2cms_pkg::CMD_START: begin
          case (step_idx)
            0:       sda = 1'b1;
            1:       scl = 1'b1;
            2:       sda = 1'b0;
            default: scl = 1'b0;
          endcase
        end
        i2cms_pkg::CMD_STOP: begin
          case (step_idx)
            0:       sda = 1'b0;
            1:       scl = 1'b1;
            default: sda = 1'b1;
          endcase
        end
        i2cms_pkg::CMD_WRITE: begin
          case (step_idx % 3)
            i2cms_pkg::PH_FIRST:  sda = shift_reg[i2cms_pkg::DATA_W-1];
            i2cms_pkg::PH_SECOND: scl = 1'b1;
            default: begin
              scl = 1'b0;
              shift_reg = shift_reg << 1;
            end
          endcase
        end
        i2cms_pkg::CMD_READ: begin
          if (step_idx == 0) begin
            sda = 1'b1;
          end else begin
            case ((step_idx - 1) % 3)
              i2cms_pkg::PH_FIRST:  scl = 1'b1;
              i2cms_pkg::PH_SECOND: shift_reg = {shift_reg[i2cms_pkg::DATA_W-2:0], sda_in};
              default:              scl = 1'b0;
            endcase
          end
        end
        i2cms_pkg::CMD_SEND_ACK: begin
          if (step_idx == 1) scl = 1'b1;
          else if (step_idx == 2) scl = 1'b0;
        end
        default: begin
          case (step_idx)
            0:       sda = 1'b1;
            1:       scl = 1'b1;
            2:       rx_ack = sda_in;
            default: scl = 1'b0;
          endcase
        end
      endcase
    endfunction

    function void predict_pins(i2cms_pkg::req_item_t it);
      pin_result_t r;
      logic        done;
      logic        rej;
      int unsigned lim;
      done = 1'b0;
      rej  = 1'b0;
      lim  = (step_ticks == 0) ? 1 : step_ticks;
      if (it.kind == i2cms_pkg::KIND_COMMAND) begin
        if (busy) begin
          rej = 1'b1;
        end else if (it.command <= i2cms_pkg::CMD_READ_ACK) begin
          active_cmd = i2cms_pkg::cmd_t'(it.command);
          step_idx   = '0;
          tick_cnt   = '0;
          busy       = 1'b1;
          case (active_cmd)
            i2cms_pkg::CMD_WRITE:    shift_reg = it.write_data;
            i2cms_pkg::CMD_READ:     shift_reg = '0;
            i2cms_pkg::CMD_SEND_ACK: sda = it.ack_out;
            default: ;
          endcase
          apply_step(it.sda_sample);
        end
      end else if (busy) begin
        tick_cnt++;
        if (tick_cnt >= lim) begin
          tick_cnt = '0;
          if (step_idx + 1 >= op_steps(active_cmd)) begin
            busy     = 1'b0;
            done     = 1'b1;
            step_idx = '0;
            if (active_cmd == i2cms_pkg::CMD_READ) rx_byte = shift_reg;
          end else begin
            step_idx++;
            apply_step(it.sda_sample);
          end
        end
      end
      r = '{scl, sda, busy, done, rx_byte, rx_ack, rej};
      pending_pins.push_back(r);
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_pins(pin_result_t got);
      pin_result_t want;
      if (pending_pins.size() == 0) begin
        errors++;
        $display("%0t: response with no expectation waiting, actual %p", $time, got);
        return;
      end
      want = pending_pins.pop_front();
      field_check("scl_level", want.scl_level, got.scl_level);
      field_check("sda_level", want.sda_level, got.sda_level);
      field_check("busy_res", want.busy_res, got.busy_res);
      field_check("done_res", want.done_res, got.done_res);
      field_check("read_data", want.read_data, got.read_data);
      field_check("ack_in", want.ack_in, got.ack_in);
      field_check("rejected", want.rejected, got.rejected);
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         step_ticks_we;
  logic [i2cms_pkg::TICK_W-1:0] step_ticks_wdata;
  logic                         hold_toggle;
  logic                         seen_toggle;
  int unsigned                  hold_left;
  int unsigned                  src_idle_pct;
  int unsigned                  snk_idle_pct;
  int unsigned                  items_sent;
  int unsigned                  cycle_count;
  pin_scoreboard                sb;

  i2cms_req_if req ();
  i2cms_rsp_if rsp ();

  i2c_master_bit_sequencer u_dut (
    .clk              (clk),
    .rst              (rst),
    .step_ticks_we    (step_ticks_we),
    .step_ticks_wdata (step_ticks_wdata),
    .req              (req),
    .rsp              (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver checks each response transfer and honours a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        sb.check_pins('{rsp.scl_level, rsp.sda_level, rsp.busy_res, rsp.done_res,
                        rsp.read_data, rsp.ack_in, rsp.rejected});
      end
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic i2cms_pkg::req_item_t noise_item();
    i2cms_pkg::req_item_t it;
    it.kind       = 1'($urandom_range(1));
    it.command    = 3'($urandom_range(7));
    it.write_data = 8'($urandom_range(255));
    it.ack_out    = 1'($urandom_range(1));
    it.sda_sample = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_item(i2cms_pkg::req_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.kind       <= it.kind;
    req.command    <= it.command;
    req.write_data <= it.write_data;
    req.ack_out    <= it.ack_out;
    req.sda_sample <= it.sda_sample;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.predict_pins(it);
    items_sent++;
  endtask

  task automatic send_command(logic [2:0] code);
    i2cms_pkg::req_item_t it;
    it         = noise_item();
    it.kind    = i2cms_pkg::KIND_COMMAND;
    it.command = code;
    send_item(it);
  endtask

  task automatic send_tick();
    i2cms_pkg::req_item_t it;
    it      = noise_item();
    it.kind = i2cms_pkg::KIND_TICK;
    send_item(it);
  endtask

  task automatic run_until_idle();
    while (sb.busy) begin
      send_tick();
      if ($urandom_range(99) < 4) send_command(3'($urandom_range(7)));
    end
  endtask

  task automatic run_op(i2cms_pkg::cmd_t code, logic [i2cms_pkg::DATA_W-1:0] wdata,
                        logic ack);
    i2cms_pkg::req_item_t it;
    it            = noise_item();
    it.kind       = i2cms_pkg::KIND_COMMAND;
    it.command    = code;
    it.write_data = wdata;
    it.ack_out    = ack;
    send_item(it);
    while (sb.busy) send_tick();
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step_ticks(logic [i2cms_pkg::TICK_W-1:0] value);
    drain();
    step_ticks_we    <= 1'b1;
    step_ticks_wdata <= value;
    @(posedge clk);
    step_ticks_we <= 1'b0;
    sb.step_ticks = value;
  endtask

  task automatic random_ops(int unsigned count);
    int unsigned target;
    int unsigned r;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_command($urandom_range(1) ? CMD_UNUSED_7 : CMD_UNUSED_6);
      end else if (r < 12) begin
        send_tick();
      end else if (r < 15) begin
        drain();
      end else begin
        send_command(3'($urandom_range(i2cms_pkg::CMD_READ_ACK)));
        if (r < 25) repeat ($urandom_range(6)) send_tick();
        else run_until_idle();
      end
    end
  endtask

  initial begin
    sb               = new();
    rst              = 1'b1;
    step_ticks_we    = 1'b0;
    step_ticks_wdata = '0;
    hold_toggle      = 1'b0;
    seen_toggle      = 1'b0;
    hold_left        = 0;
    items_sent       = 0;
    cycle_count      = 0;
    src_idle_pct     = 16;
    snk_idle_pct     = 50;
    req.valid        = 1'b0;
    req.kind         = i2cms_pkg::KIND_TICK;
    req.command      = '0;
    req.write_data   = '0;
    req.ack_out      = 1'b0;
    req.sda_sample   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_tick();
    send_command(CMD_UNUSED_6);
    send_command(CMD_UNUSED_7);
    send_command(i2cms_pkg::CMD_START);
    repeat (9) send_tick();
    send_command(i2cms_pkg::CMD_STOP);
    write_step_ticks('0);
    run_until_idle();
    run_op(i2cms_pkg::CMD_STOP, 8'h00, 1'b0);
    run_op(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b1);
    run_op(i2cms_pkg::CMD_READ, 8'h00, 1'b0);
    run_op(i2cms_pkg::CMD_SEND_ACK, 8'hFF, 1'b0);
    run_op(i2cms_pkg::CMD_SEND_ACK, 8'h00, 1'b1);
    run_op(i2cms_pkg::CMD_READ_ACK, 8'hA5, 1'b0);

    write_step_ticks(16'd1);
    random_ops(90);

    src_idle_pct = 50;
    snk_idle_pct = 16;
    write_step_ticks(16'hFFFF);
    send_command(i2cms_pkg::CMD_READ_ACK);
    repeat (5) send_tick();
    write_step_ticks(16'd2);
    random_ops(90);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_step_ticks(16'd3);
    hold_toggle <= ~hold_toggle;
    random_ops(90);
    write_step_ticks(16'hFFFF);
    send_command(i2cms_pkg::CMD_START);
    repeat (12) send_tick();
    write_step_ticks(16'd1);
    run_until_idle();

    drain();
    repeat (6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
